>>> hw/rtl/sba_pkg.sv
// Types and codes shared by the slab block allocator.
// Holds the request and response structures and the per-slot entry format.
// No dependencies.
`timescale 1ns / 1ps

package sba_pkg;

	localparam int ADDR_W = 23;
	localparam int MAP_W  = 128;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_HUGE    = 3'd2,
		ST_OOM     = 3'd3,
		ST_MISSING = 3'd4,
		ST_INVALID = 3'd5,
		ST_CLEARED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CLS_SMALL  = 2'd0,
		CLS_MEDIUM = 2'd1,
		CLS_LARGE  = 2'd2,
		CLS_HUGE   = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		CFG_SMALL  = 2'd0,
		CFG_MEDIUM = 2'd1,
		CFG_LARGE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLASS, S_SCAN_RD, S_SCAN_CHK, S_FIND, S_OPEN,
		S_FREE_RD, S_FREE_CHK, S_FREE_WAIT, S_FREE_RANGE, S_DIV, S_FREE_BIT,
		S_MUL_WAIT, S_COMMIT, S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] request_size;
		logic [22:0] free_address;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [22:0] block_address;
		logic [1:0]  block_class;
		logic [3:0]  slab_slot;
		logic [6:0]  block_index;
		logic [47:0] used_bytes_now;
		logic [31:0] live_blocks;
		logic [31:0] spare_blocks;
		logic [4:0]  open_slabs;
		logic [47:0] bytes_allocated_total;
		logic [47:0] bytes_freed_total;
	} rsp_t;

	typedef struct packed {
		logic [1:0]       cls;
		logic [7:0]       avail;
		logic [MAP_W-1:0] used_map;
	} slot_entry_t;

endpackage

>>> hw/rtl/slab_block_allocator_core.sv
// Slab block allocator: size classing, slot scan, first-free search and free lookup.
// Uses sba_pkg for the request, response and slot entry types.
`timescale 1ns / 1ps

// One request is taken at a time. Allocation scans the open slabs, reading and
// then checking each slab in turn, then searches the used map eight blocks per
// cycle. A free turns the offset into a block index with a seven-step restoring
// divider. Huge requests, clears and zero-size requests go from classing straight
// to the response step. The next request is accepted in the cycle after the
// response is offered, and a response that is still stalled holds the block in
// its last step. Slab state lives in a slot memory with one port; slabs at or
// above the open count are never read, so clear needs no sweep.
module slab_block_allocator_core #(
	parameter int MAX_SLABS      = 16,
	parameter int SMALL_BLOCKS   = 128,
	parameter int MEDIUM_BLOCKS  = 64,
	parameter int LARGE_BLOCKS   = 16,
	parameter int SLOT_ADDR_BITS = 19
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sba_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sba_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	import sba_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SLABS + 1);
	localparam int SLOT_W = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
	localparam logic [ADDR_W-1:0] OFF_MASK = (SLOT_ADDR_BITS >= ADDR_W) ? '1 :
		ADDR_W'((64'd1 << SLOT_ADDR_BITS) - 64'd1);

	function automatic logic [7:0] class_count(input logic [1:0] c);
		case (c)
			CLS_SMALL:  class_count = 8'(SMALL_BLOCKS);
			CLS_MEDIUM: class_count = 8'(MEDIUM_BLOCKS);
			default:    class_count = 8'(LARGE_BLOCKS);
		endcase
	endfunction

	state_t state_q, state_d;
	slot_entry_t slot_mem [MAX_SLABS];
	slot_entry_t rd_q, wr_data;
	logic mem_we;

	logic [12:0] small_q;
	logic [13:0] medium_q;
	logic [15:0] large_q;

	logic [1:0]  op_q;
	logic [31:0] size_q;
	logic [22:0] addr_q;
	logic [1:0]  cls_q, slab_cls_q;
	logic [2:0]  status_q;
	logic [CNT_W-1:0] scan_q, slab_cnt_q;
	logic [7:0]  fc_q;
	logic [MAP_W-1:0] map_q;
	logic [3:0]  chunk_q;
	logic [6:0]  idx_q;
	logic [7:0]  mul_a_q;
	logic [15:0] bs_q;
	logic [23:0] mul_q;
	logic [22:0] rem_q;
	logic [2:0]  step_q;
	logic [22:0] baddr_q;
	logic [47:0] used_q, alloc_q, freed_q;
	logic [31:0] live_q, spare_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [15:0] bytes_of_slab;
	logic [22:0] addr_slot, addr_off, slot_base;
	logic [1:0]  size_cls;
	logic        find_hit, find_end, div_take;
	logic [2:0]  find_k;
	logic [23:0] div_trial;
	logic        out_free;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		case (slab_cls_q)
			CLS_SMALL:  bytes_of_slab = {3'd0, small_q};
			CLS_MEDIUM: bytes_of_slab = {2'd0, medium_q};
			default:    bytes_of_slab = large_q;
		endcase
	end

	always_comb begin
		if (size_q <= {19'd0, small_q})
			size_cls = CLS_SMALL;
		else if (size_q <= {18'd0, medium_q})
			size_cls = CLS_MEDIUM;
		else if (size_q <= {16'd0, large_q})
			size_cls = CLS_LARGE;
		else
			size_cls = CLS_HUGE;
	end

	assign addr_slot = addr_q >> SLOT_ADDR_BITS;
	assign addr_off  = addr_q & OFF_MASK;
	assign slot_base = ADDR_W'({{(64 - CNT_W){1'b0}}, scan_q} << SLOT_ADDR_BITS);

	always_comb begin
		find_hit = 1'b0;
		find_k   = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (!map_q[{chunk_q, 3'(k)}] && ({1'b0, chunk_q, 3'(k)} < class_count(slab_cls_q)))
			begin
				find_hit = 1'b1;
				find_k   = 3'(k);
			end
		end
		find_end = ({chunk_q, 3'd0} + 8'd8) >= class_count(slab_cls_q);
	end

	assign div_trial = {1'b0, rem_q} - ({8'd0, bs_q} << step_q);
	assign div_take  = !div_trial[23];

	always_comb begin
		mem_we  = (state_q == S_COMMIT);
		wr_data.cls = slab_cls_q;
		if (op_q == OP_ALLOC) begin
			wr_data.avail    = fc_q - 8'd1;
			wr_data.used_map = map_q | (MAP_W'(1) << idx_q);
		end else begin
			wr_data.avail    = fc_q + 8'd1;
			wr_data.used_map = map_q & ~(MAP_W'(1) << idx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			slot_mem[scan_q[SLOT_W-1:0]] <= wr_data;
		rd_q <= slot_mem[scan_q[SLOT_W-1:0]];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req_valid) state_d = S_CLASS;
			S_CLASS: begin
				if (op_q == OP_ALLOC && size_q != 32'd0 && size_cls != CLS_HUGE)
					state_d = S_SCAN_RD;
				else if (op_q == OP_FREE && size_cls != CLS_HUGE)
					state_d = S_FREE_RD;
				else
					state_d = S_DONE;
			end
			S_SCAN_RD: state_d = (scan_q >= slab_cnt_q) ? S_OPEN : S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (rd_q.cls == cls_q && rd_q.avail != 8'd0)
					state_d = S_FIND;
				else
					state_d = S_SCAN_RD;
			end
			S_FIND: begin
				if (find_hit)
					state_d = S_MUL_WAIT;
				else if (find_end)
					state_d = S_SCAN_RD;
			end
			S_OPEN: state_d = (slab_cnt_q >= CNT_W'(MAX_SLABS)) ? S_DONE : S_MUL_WAIT;
			S_FREE_RD: state_d = (addr_slot < 23'(slab_cnt_q)) ? S_FREE_CHK : S_DONE;
			S_FREE_CHK: state_d = S_FREE_WAIT;
			S_FREE_WAIT: state_d = S_FREE_RANGE;
			S_FREE_RANGE: begin
				if (bs_q == 16'd0 || {1'b0, addr_off} >= mul_q)
					state_d = S_DONE;
				else
					state_d = S_DIV;
			end
			S_DIV: if (step_q == 3'd0) state_d = S_FREE_BIT;
			S_FREE_BIT: state_d = map_q[idx_q] ? S_MUL_WAIT : S_DONE;
			S_MUL_WAIT: state_d = S_COMMIT;
			S_COMMIT: state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			small_q     <= 13'd64;
			medium_q    <= 14'd256;
			large_q     <= 16'd1024;
			slab_cnt_q  <= '0;
			used_q      <= '0;
			alloc_q     <= '0;
			freed_q     <= '0;
			live_q      <= '0;
			spare_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SMALL:  small_q  <= cfg_data[12:0];
					CFG_MEDIUM: medium_q <= cfg_data[13:0];
					CFG_LARGE:  large_q  <= cfg_data;
					default:    ;
				endcase
			end
			if (state_q == S_DONE && out_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_CLASS: begin
					if (op_q == OP_CLEAR) begin
						slab_cnt_q <= '0;
						used_q     <= '0;
						alloc_q    <= '0;
						freed_q    <= '0;
						live_q     <= '0;
						spare_q    <= '0;
					end else if (op_q == OP_ALLOC && size_q != 32'd0 && size_cls == CLS_HUGE)
					begin
						alloc_q <= alloc_q + {16'd0, size_q};
						used_q  <= used_q + {16'd0, size_q};
						live_q  <= live_q + 32'd1;
					end else if (op_q == OP_FREE && size_cls == CLS_HUGE) begin
						freed_q <= freed_q + {16'd0, size_q};
						used_q  <= used_q - {16'd0, size_q};
						live_q  <= live_q - 32'd1;
					end
				end
				S_OPEN: begin
					if (slab_cnt_q < CNT_W'(MAX_SLABS)) begin
						slab_cnt_q <= slab_cnt_q + CNT_W'(1);
						spare_q    <= spare_q + {24'd0, class_count(cls_q)};
					end
				end
				S_COMMIT: begin
					if (op_q == OP_ALLOC) begin
						alloc_q <= alloc_q + {16'd0, size_q};
						used_q  <= used_q + {16'd0, size_q};
						live_q  <= live_q + 32'd1;
						spare_q <= spare_q - 32'd1;
					end else begin
						freed_q <= freed_q + {16'd0, size_q};
						used_q  <= used_q - {16'd0, size_q};
						live_q  <= live_q - 32'd1;
						spare_q <= spare_q + 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= {16'd0, mul_a_q} * {8'd0, bs_q};
		case (state_q)
			S_IDLE: begin
				op_q    <= req.operation;
				size_q  <= req.request_size;
				addr_q  <= req.free_address;
				baddr_q <= '0;
				idx_q   <= '0;
			end
			S_CLASS: begin
				scan_q     <= (op_q == OP_FREE) ? addr_slot[CNT_W-1:0] : '0;
				slab_cls_q <= size_cls;
				cls_q      <= (op_q == OP_CLEAR || op_q == OP_NONE ||
					(op_q == OP_ALLOC && size_q == 32'd0)) ? CLS_SMALL : size_cls;
				if (op_q == OP_CLEAR)
					status_q <= ST_CLEARED;
				else if (op_q == OP_ALLOC && size_q == 32'd0)
					status_q <= ST_ZERO;
				else if ((op_q == OP_ALLOC || op_q == OP_FREE) && size_cls == CLS_HUGE)
					status_q <= ST_HUGE;
				else if (op_q == OP_FREE)
					status_q <= ST_MISSING;
				else
					status_q <= ST_INVALID;
			end
			S_SCAN_CHK: begin
				if (rd_q.cls == cls_q && rd_q.avail != 8'd0) begin
					map_q   <= rd_q.used_map;
					fc_q    <= rd_q.avail;
					chunk_q <= '0;
				end else
					scan_q <= scan_q + CNT_W'(1);
			end
			S_FIND: begin
				if (find_hit) begin
					idx_q   <= {chunk_q, find_k};
					mul_a_q <= {1'b0, chunk_q, find_k};
					bs_q    <= bytes_of_slab;
				end else if (find_end)
					scan_q <= scan_q + CNT_W'(1);
				else
					chunk_q <= chunk_q + 4'd1;
			end
			S_OPEN: begin
				if (slab_cnt_q >= CNT_W'(MAX_SLABS))
					status_q <= ST_OOM;
				scan_q  <= slab_cnt_q;
				map_q   <= '0;
				fc_q    <= class_count(cls_q);
				idx_q   <= '0;
				mul_a_q <= '0;
				bs_q    <= bytes_of_slab;
			end
			S_FREE_RD: scan_q <= addr_slot[CNT_W-1:0];
			S_FREE_CHK: begin
				slab_cls_q <= rd_q.cls;
				map_q      <= rd_q.used_map;
				fc_q       <= rd_q.avail;
				case (rd_q.cls)
					CLS_SMALL:  bs_q <= {3'd0, small_q};
					CLS_MEDIUM: bs_q <= {2'd0, medium_q};
					default:    bs_q <= large_q;
				endcase
				mul_a_q <= class_count(rd_q.cls);
			end
			S_FREE_RANGE: begin
				rem_q  <= addr_off;
				step_q <= 3'd6;
				idx_q  <= '0;
			end
			S_DIV: begin
				if (div_take) begin
					rem_q         <= div_trial[22:0];
					idx_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 3'd1;
			end
			S_FREE_BIT: begin
				mul_a_q <= {1'b0, idx_q};
				if (!map_q[idx_q])
					status_q <= ST_INVALID;
			end
			S_COMMIT: begin
				status_q <= ST_OK;
				baddr_q  <= slot_base + mul_q[22:0];
			end
			S_DONE: begin
				if (out_free) begin
					rsp_q.status                <= status_q;
					rsp_q.block_address         <= (status_q == ST_OK) ? baddr_q : '0;
					rsp_q.block_class           <= cls_q;
					rsp_q.slab_slot             <= (status_q == ST_OK) ? 4'(scan_q) : 4'd0;
					rsp_q.block_index           <= (status_q == ST_OK) ? idx_q : 7'd0;
					rsp_q.used_bytes_now        <= used_q;
					rsp_q.live_blocks           <= live_q;
					rsp_q.spare_blocks          <= spare_q;
					rsp_q.open_slabs            <= 5'(slab_cnt_q);
					rsp_q.bytes_allocated_total <= alloc_q;
					rsp_q.bytes_freed_total     <= freed_q;
				end
			end
			default: ;
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slab_cnt_q <= CNT_W'(MAX_SLABS))
		else $error("open slab count exceeds slot count");
	a_alloc_free_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && op_q == OP_ALLOC) |-> !map_q[idx_q])
		else $error("allocation takes a block already in use");
	a_free_used_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && op_q == OP_FREE) |-> map_q[idx_q])
		else $error("free releases a block not in use");
	a_done_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (state_q == S_IDLE && rsp_valid))
		else $error("finished request did not reach the response register");

endmodule
